// ===== rtl/gcd_pkg.sv =====
// Shared constants and controller/datapath interface types for the GCD block.
package gcd_pkg;

	localparam int OPERAND_BITS = 32;
	localparam int MAG_BITS     = OPERAND_BITS - 1;
	localparam int SHIFT_BITS   = $clog2(MAG_BITS + 1);

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture operands of an accepted transaction
		logic step;   // one binary GCD reduction step
		logic emit;   // move the finished result into the output register
	} gcd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic done;   // working magnitudes are equal
	} gcd_status_t;

endpackage

// ===== rtl/gcd_datapath.sv =====
// Datapath: working magnitudes, common power-of-two count and result register.
module gcd_datapath
	import gcd_pkg::*;
(
	input  logic                          clk,
	input  gcd_cmd_t                      cmd,
	output gcd_status_t                   status,
	input  logic signed [OPERAND_BITS-1:0] first_operand,
	input  logic signed [OPERAND_BITS-1:0] second_operand,
	output logic        [MAG_BITS-1:0]     divisor,
	output logic                           defined
);

	logic [MAG_BITS-1:0]   a_q, b_q;
	logic [SHIFT_BITS-1:0] k_q;
	logic                  def_q;
	logic [MAG_BITS-1:0]   divisor_q;
	logic                  defined_q;

	logic                  a_pos, b_pos, both_pos;
	logic                  a_gt;
	logic [MAG_BITS-1:0]   diff;

	// positive: sign clear and nonzero
	assign a_pos    = !first_operand[OPERAND_BITS-1] && (first_operand != '0);
	assign b_pos    = !second_operand[OPERAND_BITS-1] && (second_operand != '0);
	assign both_pos = a_pos && b_pos;

	assign a_gt = a_q > b_q;
	assign diff = a_gt ? (a_q - b_q) : (b_q - a_q);

	assign status.done = (a_q == b_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			// undefined case parks both at zero so the run ends at once with 0
			a_q   <= both_pos ? first_operand[MAG_BITS-1:0]  : '0;
			b_q   <= both_pos ? second_operand[MAG_BITS-1:0] : '0;
			k_q   <= '0;
			def_q <= both_pos;
		end else if (cmd.step) begin
			case ({a_q[0], b_q[0]})
				2'b00: begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + SHIFT_BITS'(1);
				end
				2'b01: begin
					a_q <= a_q >> 1;
				end
				2'b10: begin
					b_q <= b_q >> 1;
				end
				default: begin
					// both odd: difference is even, halve it
					if (a_gt) begin
						a_q <= diff >> 1;
					end else begin
						b_q <= diff >> 1;
					end
				end
			endcase
		end
		if (cmd.emit) begin
			divisor_q <= a_q << k_q;
			defined_q <= def_q;
		end
	end

	assign divisor = divisor_q;
	assign defined = defined_q;

endmodule

// ===== rtl/gcd_control.sv =====
// Controller: transaction handshakes, run sequencing and output valid.
module gcd_control
	import gcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output gcd_cmd_t    cmd,
	input  gcd_status_t status
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q, state_d;
	logic out_valid_q;
	logic slot_free;
	logic accept;
	logic taken;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign taken     = out_valid_q && !out_stall;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!status.done) begin
					cmd.step = 1'b1;
				end else if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (taken) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/greatest_common_divisor.sv =====
// An accepted input is loaded, reduced by binary GCD steps until the magnitudes are equal,
// then emitted into the output register once it is free; undefined inputs need no steps.
// The single step unit holds one transaction at a time: input stalls while a run is busy.
// A new input is taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) clears the controller and the output valid only.
// Zero or negative operands give divisor 0 with defined clear.
module greatest_common_divisor
	import gcd_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	// input transaction
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [OPERAND_BITS-1:0] first_operand,
	input  logic signed [OPERAND_BITS-1:0] second_operand,
	// output transaction
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic        [MAG_BITS-1:0]     divisor,
	output logic                           defined
);

	gcd_cmd_t    cmd;
	gcd_status_t status;

	// Controller: idle -> run (one binary GCD step per cycle) -> emit into output register.
	gcd_control u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath: two magnitudes reduced by halving or halved difference until
	// equal; the common factor of two is counted and shifted back at the end.
	gcd_datapath u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.status         (status),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.divisor        (divisor),
		.defined        (defined)
	);

endmodule

// ===== tb/tb_greatest_common_divisor.sv =====
// Self-checking testbench for greatest_common_divisor: directed table, then random transactions.
module tb_greatest_common_divisor;
	import gcd_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int TAIL_CYCLES  = 80;      // past the longest step-unit latency
	localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
	localparam int HOLD_AT      = 700;     // transactions accepted before the hold starts
	localparam int PAUSE_AT     = 1200;    // random item after which the sender drains

	localparam logic signed [OPERAND_BITS-1:0] MOST_POS = 32'sh7FFF_FFFF;
	localparam logic signed [OPERAND_BITS-1:0] MOST_NEG = 32'sh8000_0000;
	localparam logic        [MAG_BITS-1:0]     MAG_MAX  = {MAG_BITS{1'b1}};

	typedef struct packed {
		logic [MAG_BITS-1:0] divisor;
		logic                defined;
	} gcd_result_t;

	localparam gcd_result_t NO_GCD = '{divisor: '0, defined: 1'b0};

	// typed = 1: the expected result is the one in the row, else the predictor decides
	typedef struct packed {
		logic signed [OPERAND_BITS-1:0] first;
		logic signed [OPERAND_BITS-1:0] second;
		logic                           typed;
		gcd_result_t                    want;
	} vector_t;

	typedef struct {
		logic signed [OPERAND_BITS-1:0] first;
		logic signed [OPERAND_BITS-1:0] second;
		gcd_result_t                    want;
	} pending_t;

	localparam int DIRECTED_COUNT = 23;

	vector_t directed_vectors [DIRECTED_COUNT] = '{
		'{32'sd12,          32'sd18,          1'b0, NO_GCD},
		'{32'sd1,           32'sd1,           1'b1, '{31'd1, 1'b1}},
		'{MOST_POS,         MOST_POS,         1'b1, '{MAG_MAX, 1'b1}},
		'{32'sd1,           MOST_POS,         1'b1, '{31'd1, 1'b1}},
		'{MOST_POS,         32'sd1,           1'b1, '{31'd1, 1'b1}},
		'{32'sd0,           32'sd0,           1'b1, NO_GCD},
		'{32'sd0,           32'sd5,           1'b1, NO_GCD},
		'{32'sd7,           32'sd0,           1'b1, NO_GCD},
		'{-32'sd1,          32'sd9,           1'b1, NO_GCD},
		'{32'sd9,           -32'sd1,          1'b1, NO_GCD},
		'{-32'sd1,          -32'sd1,          1'b1, NO_GCD},
		'{MOST_NEG,         MOST_NEG,         1'b1, NO_GCD},
		'{MOST_NEG,         MOST_POS,         1'b1, NO_GCD},
		'{MOST_POS,         MOST_NEG,         1'b1, NO_GCD},
		'{MOST_NEG,         32'sd0,           1'b1, NO_GCD},
		'{32'sd1000,        32'sd1000,        1'b1, '{31'd1000, 1'b1}},
		'{32'sh4000_0000,   32'sh2000_0000,   1'b0, NO_GCD},
		// consecutive Fibonacci numbers: longest remainder chain
		'{32'sd1836311903,  32'sd1134903170,  1'b0, NO_GCD},
		'{32'sd2147483646,  32'sd1073741823,  1'b0, NO_GCD},
		'{32'sh5555_5555,   32'sh2AAA_AAAA,   1'b0, NO_GCD},
		'{32'sh7FFF_FFFE,   32'sh7FFF_FFFC,   1'b0, NO_GCD},
		'{32'sd13,          32'sd1261,        1'b0, NO_GCD},
		'{32'sd64,          32'sd48,          1'b0, NO_GCD}
	};

	logic                           clk            = 1'b0;
	logic                           arst_n         = 1'b0;
	logic                           in_valid       = 1'b0;
	logic                           in_stall;
	logic signed [OPERAND_BITS-1:0] first_operand  = '0;
	logic signed [OPERAND_BITS-1:0] second_operand = '0;
	logic                           out_valid;
	logic                           out_stall      = 1'b0;
	logic        [MAG_BITS-1:0]     divisor;
	logic                           defined;

	pending_t    results_due [$];
	int unsigned mismatch_count = 0;
	int unsigned accepted_count = 0;
	int unsigned cycle_count    = 0;
	logic        calm           = 1'b0;   // stretch with no idling on either side
	logic        long_hold      = 1'b0;

	greatest_common_divisor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.divisor        (divisor),
		.defined        (defined)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Euclid on the positive magnitudes; anything zero or negative has no divisor.
	function automatic gcd_result_t predict_gcd(input logic signed [OPERAND_BITS-1:0] first,
			input logic signed [OPERAND_BITS-1:0] second);
		logic [OPERAND_BITS-1:0] x;
		logic [OPERAND_BITS-1:0] y;
		logic [OPERAND_BITS-1:0] r;
		gcd_result_t             res;
		res = NO_GCD;
		if (first > 0 && second > 0) begin
			x = first;
			y = second;
			while (y != 0) begin
				r = x % y;
				x = y;
				y = r;
			end
			res.divisor = x[MAG_BITS-1:0];
			res.defined = 1'b1;
		end
		return res;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Offer one transaction after a drawn gap, hold it until taken, then log its expectation.
	task automatic send_pair(input logic signed [OPERAND_BITS-1:0] first,
			input logic signed [OPERAND_BITS-1:0] second,
			input logic typed, input gcd_result_t want);
		int unsigned gap;
		pending_t    entry;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		first_operand  <= first;
		second_operand <= second;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		entry.first  = first;
		entry.second = second;
		entry.want   = typed ? want : predict_gcd(first, second);
		results_due.push_back(entry);
		accepted_count++;
		calm <= ((accepted_count / 120) % 4) == 3;
	endtask

	// Receiver: after each accepted result draw a wait, counted only while a result is shown.
	int unsigned rx_wait = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			rx_wait = calm ? 0 : $urandom_range(0, 7);
		else if (out_valid && rx_wait != 0)
			rx_wait = rx_wait - 1;
		out_stall <= long_hold || rx_wait != 0;
	end

	// One long hold-off while the sender keeps offering, so the block backs up.
	initial begin : hold_off
		wait (accepted_count >= HOLD_AT);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	always @(posedge clk) begin : check_results
		pending_t oldest;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				flag_mismatch($sformatf("result divisor=%0d defined=%0b with none pending",
					divisor, defined));
			end else begin
				oldest = results_due.pop_front();
				if (divisor !== oldest.want.divisor)
					flag_mismatch($sformatf("gcd(%0d, %0d): divisor %0d, want %0d",
						oldest.first, oldest.second, divisor, oldest.want.divisor));
				if (defined !== oldest.want.defined)
					flag_mismatch($sformatf("gcd(%0d, %0d): defined %0b, want %0b",
						oldest.first, oldest.second, defined, oldest.want.defined));
			end
		end
	end

	initial begin : stimulus
		int unsigned                    kind;
		int unsigned                    g;
		int unsigned                    span;
		logic signed [OPERAND_BITS-1:0] a;
		logic signed [OPERAND_BITS-1:0] b;
		logic signed [OPERAND_BITS-1:0] t;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_pair(directed_vectors[i].first, directed_vectors[i].second,
				directed_vectors[i].typed, directed_vectors[i].want);

		// drain before the random part
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// shared factor of random size
				g = $urandom_range(1, 16'hFFFF) >> $urandom_range(0, 15);
				if (g == 0)
					g = 1;
				span = 32'h7FFF_FFFF / g;
				a = g * $urandom_range(1, span);
				b = g * $urandom_range(1, span);
			end else if (kind < 62) begin
				a = $urandom >> $urandom_range(1, 31);
				b = $urandom >> $urandom_range(1, 31);
			end else if (kind < 70) begin
				a = ($urandom >> $urandom_range(1, 31)) | 1;
				b = a;
			end else if (kind < 78) begin
				a = $urandom_range(1, 64);
				b = $urandom_range(1, 64);
			end else if (kind < 85) begin
				// one side zero or negative
				a = $urandom >> 1;
				b = -$signed($urandom_range(0, 16));
				if ($urandom_range(0, 1)) begin
					t = a;
					a = b;
					b = t;
				end
			end else begin
				a = $urandom;
				b = $urandom;
			end
			send_pair(a, b, 1'b0, NO_GCD);

			if (i == PAUSE_AT) begin
				// let the block run dry before going on
				in_valid <= 1'b0;
				while (results_due.size() != 0) @(posedge clk);
			end
		end

		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/gcd_pkg.sv
rtl/gcd_datapath.sv
rtl/gcd_control.sv
rtl/greatest_common_divisor.sv
tb/tb_greatest_common_divisor.sv
